@@ hdl/smeu_pkg.sv @@
// Shared types, constants and opcodes for the stack machine execute unit.
package smeu_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int NUM_REGS_DEF = 4;

  typedef enum logic [3:0] {
    CMD_BEGIN = 4'd0,
    CMD_END   = 4'd1,
    CMD_PUSH  = 4'd2,
    CMD_POP   = 4'd3,
    CMD_PUSHR = 4'd4,
    CMD_POPR  = 4'd5,
    CMD_ADD   = 4'd6,
    CMD_SUB   = 4'd7,
    CMD_MUL   = 4'd8,
    CMD_DIV   = 4'd9,
    CMD_OUT   = 4'd10,
    CMD_IN    = 4'd11
  } cmd_e;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNDER   = 3'd1;
  localparam logic [2:0] ST_OVER    = 3'd2;
  localparam logic [2:0] ST_DIVZ    = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] value;
    logic [1:0]         reg_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               out_valid;
    logic [2:0]         status;
    logic [6:0]         depth;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [31:0] a;
    logic [31:0] b;
  } md_req_t;

endpackage

@@ hdl/smeu_muldiv.sv @@
// Shared iterative multiply and signed divide unit, one bit per cycle.
module smeu_muldiv
  import smeu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  md_req_t     req,
  output logic        done,
  output logic [31:0] result
);

  logic        busy;
  logic        div_op;
  logic [5:0]  count;
  logic [31:0] acc;
  logic [31:0] mcand;
  logic [31:0] quot;
  logic [31:0] rem;
  logic [31:0] dvsr;
  logic        neg_q;
  logic [32:0] rem_shift;
  logic [32:0] rem_sub;
  logic [31:0] q_fix;

  assign rem_shift = {rem, quot[31]};
  assign rem_sub   = rem_shift - {1'b0, dvsr};
  assign q_fix     = neg_q ? (32'd0 - quot) : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        div_op <= req.is_div;
        count  <= 6'd32;
        acc    <= '0;
        mcand  <= req.a;
        dvsr   <= req.b[31] ? (32'd0 - req.b) : req.b;
        quot   <= req.is_div ? (req.a[31] ? (32'd0 - req.a) : req.a) : req.b;
        rem    <= '0;
        neg_q  <= req.a[31] ^ req.b[31];
      end else if (busy) begin
        if (count == 6'd0) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= div_op ? q_fix : acc;
        end else begin
          count <= count - 6'd1;
          if (div_op) begin
            if (!rem_sub[32]) begin
              rem  <= rem_sub[31:0];
              quot <= {quot[30:0], 1'b1};
            end else begin
              rem  <= rem_shift[31:0];
              quot <= {quot[30:0], 1'b0};
            end
          end else begin
            if (quot[0]) acc <= acc + mcand;
            mcand <= mcand << 1;
            quot  <= quot >> 1;
          end
        end
      end
    end
  end

  a_no_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without busy");
  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy after done");
  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |=> busy) else $error("start lost");

endmodule

@@ hdl/stack_machine_execute_unit.sv @@
// Top level of the stack machine execute unit.
// Each beat passes through two stack reads, execute and a registered result; mul and
// div also wait on the iterative unit. One instruction is in flight: a new beat is
// taken only in idle, after the previous result is registered.
// Reset clears the stack pointer, the register file and the handshake state;
// stack memory contents are undefined until written.
module stack_machine_execute_unit
  import smeu_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int NUM_REGS = NUM_REGS_DEF
)(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  typedef enum logic [2:0] {S_IDLE, S_RD1, S_RD2, S_EXEC, S_WAIT, S_RESP} state_t;

  state_t        state;
  in_item_t      item;
  out_item_t     resp;
  logic [PW-1:0] sp;
  logic [31:0]   mem [STACK_DEPTH];
  logic [31:0]   regs [NUM_REGS];
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic [31:0]   top_a;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  md_req_t       md_req;
  logic          md_done;
  logic [31:0]   md_result;
  logic          reg_ok;
  logic [RW-1:0] ridx;

  assign ridx   = RW'(item.reg_index);
  assign reg_ok = {30'd0, item.reg_index} < NUM_REGS;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  smeu_muldiv u_muldiv (
    .clk(clk), .rst(rst), .req(md_req), .done(md_done), .result(md_result)
  );

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    mem_we <= 1'b0;
    md_req.start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      sp <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= '0;
    end else begin
      if (out_valid && out_ready && state != S_RESP) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item    <= in_data;
            rd_addr <= AW'(sp - PW'(1));
            state   <= S_RD1;
          end
        end
        S_RD1: begin
          rd_addr <= AW'(sp - PW'(2));
          state   <= S_RD2;
        end
        S_RD2: begin
          top_a <= rd_data;
          state <= S_EXEC;
        end
        S_EXEC: begin
          resp <= '{out_value: '0, out_valid: 1'b0, status: ST_OK,
                    depth: 7'(sp)};
          state <= S_RESP;
          case (item.command)
            CMD_BEGIN, CMD_END: ;
            CMD_PUSH, CMD_IN: begin
              if (sp >= PW'(STACK_DEPTH)) resp.status <= ST_OVER;
              else begin
                mem_we <= 1'b1; wr_addr <= AW'(sp); wr_data <= item.value;
                sp <= sp + PW'(1); resp.depth <= 7'(sp + PW'(1));
              end
            end
            CMD_POP: begin
              if (sp == '0) resp.status <= ST_UNDER;
              else begin
                sp <= sp - PW'(1); resp.depth <= 7'(sp - PW'(1));
              end
            end
            CMD_OUT: begin
              if (sp == '0) resp.status <= ST_UNDER;
              else begin
                sp <= sp - PW'(1); resp.depth <= 7'(sp - PW'(1));
                resp.out_value <= top_a; resp.out_valid <= 1'b1;
              end
            end
            CMD_PUSHR: begin
              if (!reg_ok) resp.status <= ST_INVALID;
              else if (sp >= PW'(STACK_DEPTH)) resp.status <= ST_OVER;
              else begin
                mem_we <= 1'b1; wr_addr <= AW'(sp); wr_data <= regs[ridx];
                sp <= sp + PW'(1); resp.depth <= 7'(sp + PW'(1));
              end
            end
            CMD_POPR: begin
              if (!reg_ok) resp.status <= ST_INVALID;
              else if (sp == '0) resp.status <= ST_UNDER;
              else begin
                regs[ridx] <= top_a;
                sp <= sp - PW'(1); resp.depth <= 7'(sp - PW'(1));
              end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
              if (sp < PW'(2)) resp.status <= ST_UNDER;
              else if (sp >= PW'(STACK_DEPTH)) resp.status <= ST_OVER;
              else if (item.command == CMD_DIV && rd_data == '0)
                resp.status <= ST_DIVZ;
              else if (item.command == CMD_ADD || item.command == CMD_SUB) begin
                mem_we  <= 1'b1; wr_addr <= AW'(sp);
                wr_data <= (item.command == CMD_ADD) ? top_a + rd_data
                                                     : top_a - rd_data;
                sp <= sp + PW'(1); resp.depth <= 7'(sp + PW'(1));
              end else begin
                md_req <= '{start: 1'b1, is_div: item.command == CMD_DIV,
                            a: top_a, b: rd_data};
                state <= S_WAIT;
              end
            end
            default: resp.status <= ST_INVALID;
          endcase
        end
        S_WAIT: begin
          if (md_done) begin
            mem_we <= 1'b1; wr_addr <= AW'(sp); wr_data <= md_result;
            sp <= sp + PW'(1); resp.depth <= 7'(sp + PW'(1));
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_data  <= resp;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= PW'(STACK_DEPTH)) else $error("stack pointer out of range");
  a_sp_step: assert property (@(posedge clk) disable iff (rst)
    (sp != $past(sp)) |-> ($past(state) == S_EXEC || $past(state) == S_WAIT))
    else $error("stack pointer moved outside execute");
  a_resp_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |=> out_valid) else $error("response lost");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");

endmodule
